/* rtl/tshp_pkg.sv */
// tshp_pkg: shared types, constants and codes of the transient shaper
// used by tshp_lane, tshp_merge and transient_shaper; no dependencies
`default_nettype none

package tshp_pkg;

  // channel lanes and field widths
  localparam int CHANNELS   = 2;
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 24;
  localparam int GAIN_W     = 32;
  localparam int DIFF_W     = 25;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // fixed-point constants
  localparam logic [23:0] UNITY_Q20 = 24'd1048576;
  localparam logic [31:0] UNITY_Q24 = 32'd16777216;
  localparam int          FULL_Q23  = 8388608;

  typedef logic signed [DIFF_W-1:0] diff_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_CHANNELS = 4'd0,
    REG_FAST_ATTACK     = 4'd1,
    REG_FAST_RELEASE    = 4'd2,
    REG_SLOW_ATTACK     = 4'd3,
    REG_SLOW_RELEASE    = 4'd4,
    REG_SMOOTHING       = 4'd5,
    REG_TRANSIENT_GAIN  = 4'd6,
    REG_SUSTAIN_GAIN    = 4'd7
  } cfg_reg_e;

  // frame sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV_MUL,
    ST_ENV_ADD,
    ST_DIFF,
    ST_MAX,
    ST_FAC_MUL,
    ST_FAC_ADD,
    ST_TGT_MUL,
    ST_TGT_RND,
    ST_SMO_MUL,
    ST_SMO_ADD,
    ST_OUT_MUL,
    ST_OUT_RND,
    ST_DONE
  } state_t;

  // step strobes from the sequencer to lanes and merge stage
  typedef struct packed {
    logic load;
    logic env_mul;
    logic env_add;
    logic diff;
    logic max;
    logic fac_mul;
    logic fac_add;
    logic tgt_mul;
    logic tgt_rnd;
    logic smo_mul;
    logic smo_add;
    logic out_mul;
    logic out_rnd;
    logic clear;
  } seq_ctrl_t;

endpackage

`default_nettype wire

/* rtl/tshp_lane.sv */
// tshp_lane: one channel lane; fast and slow envelopes, envelope difference,
// and the gain multiply with rounding and saturation; uses tshp_pkg
`default_nettype none

module tshp_lane (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire tshp_pkg::seq_ctrl_t                   ctrl,
  input  wire logic                                  act,
  input  wire logic signed [tshp_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic        [tshp_pkg::COEF_W-1:0]    fast_att,
  input  wire logic        [tshp_pkg::COEF_W-1:0]    fast_rel,
  input  wire logic        [tshp_pkg::COEF_W-1:0]    slow_att,
  input  wire logic        [tshp_pkg::COEF_W-1:0]    slow_rel,
  input  wire logic        [tshp_pkg::GAIN_W-1:0]    gain,
  output tshp_pkg::diff_t                            diff,
  output logic signed      [tshp_pkg::SAMPLE_W-1:0]  y
);
  import tshp_pkg::*;

  logic signed [SAMPLE_W-1:0] samp;
  logic        [SAMPLE_W-1:0] mag;
  logic        [SAMPLE_W-1:0] fenv;
  logic        [SAMPLE_W-1:0] senv;
  logic signed [49:0]         fprod;
  logic signed [49:0]         sprod;
  logic signed [56:0]         oprod;

  logic        [COEF_W-1:0]   fcoef;
  logic        [COEF_W-1:0]   scoef;
  logic signed [24:0]         fdelta;
  logic signed [24:0]         sdelta;
  logic signed [49:0]         fsum;
  logic signed [49:0]         ssum;
  logic        [56:0]         pabs;
  logic        [32:0]         q;

  // pole select and envelope sums: prev*c + mag*(1-c) = mag + (prev-mag)*c
  always_comb begin
    fcoef  = (mag > fenv) ? fast_att : fast_rel;
    scoef  = (mag > senv) ? slow_att : slow_rel;
    fdelta = $signed({1'b0, fenv}) - $signed({1'b0, mag});
    sdelta = $signed({1'b0, senv}) - $signed({1'b0, mag});
    fsum   = $signed({2'b00, mag, 24'b0}) + fprod + 50'sd8388608;
    ssum   = $signed({2'b00, mag, 24'b0}) + sprod + 50'sd8388608;
  end

  // output rounding, half away from zero
  always_comb begin
    pabs = oprod[56] ? $unsigned(-oprod) : $unsigned(oprod);
    q    = 33'((pabs + 57'(FULL_Q23)) >> 24);
  end

  // envelope state
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      fenv <= '0;
      senv <= '0;
    end else if (ctrl.env_add && act) begin
      fenv <= fsum[47:24];
      senv <= ssum[47:24];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      samp <= sample;
      mag  <= sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
      y    <= sample;
    end
    if (ctrl.env_mul) begin
      fprod <= fdelta * $signed({1'b0, fcoef});
      sprod <= sdelta * $signed({1'b0, scoef});
    end
    if (ctrl.diff) begin
      diff <= act ? ($signed({1'b0, fenv}) - $signed({1'b0, senv})) : '0;
    end
    if (ctrl.out_mul) begin
      oprod <= samp * $signed({1'b0, gain});
    end
    if (ctrl.out_rnd) begin
      if (!act) begin
        y <= '0;
      end else if (oprod[56]) begin
        y <= (q >= 33'(FULL_Q23)) ? -24'sd8388608 : -$signed({1'b0, q[22:0]});
      end else begin
        y <= (q > 33'(FULL_Q23 - 1)) ? 24'sd8388607 : $signed(q[23:0]);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tshp_merge.sv */
// tshp_merge: combines the lane differences into the transient amount,
// forms and smooths the target gain; uses tshp_pkg
`default_nettype none

module tshp_merge (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tshp_pkg::seq_ctrl_t                 ctrl,
  input  wire tshp_pkg::diff_t                     diffs [tshp_pkg::CHANNELS],
  input  wire logic        [tshp_pkg::COEF_W-1:0]  trans_gain,
  input  wire logic        [tshp_pkg::COEF_W-1:0]  sust_gain,
  input  wire logic        [tshp_pkg::COEF_W-1:0]  smoothing,
  output logic             [tshp_pkg::GAIN_W-1:0]  gain
);
  import tshp_pkg::*;

  logic        [23:0]       maxd;
  logic signed [49:0]       tprod;
  logic signed [49:0]       sprod;
  logic        [23:0]       tv;
  logic        [23:0]       sv;
  logic        [47:0]       tsp;
  logic        [GAIN_W-1:0] target;
  logic signed [57:0]       smprod;

  diff_t              m;
  logic signed [24:0] tdelta;
  logic signed [24:0] sdelta;
  logic signed [24:0] xt;
  logic signed [24:0] xs;
  logic        [32:0] t33;
  logic signed [32:0] gdelta;
  logic signed [57:0] gsum;
  logic        [33:0] g34;

  // 1 + round((G-1)*x), floored at zero, Q4.20
  function automatic logic [23:0] shape(input logic signed [49:0] p);
    logic        [49:0] pabs;
    logic        [25:0] qq;
    logic signed [26:0] r;
    logic signed [26:0] f;
    pabs = p[49] ? $unsigned(-p) : $unsigned(p);
    qq   = 26'((pabs + 50'(2 ** 22)) >> 23);
    r    = p[49] ? -$signed({1'b0, qq}) : $signed({1'b0, qq});
    f    = 27'sd1048576 + r;
    return f[26] ? 24'd0 : f[23:0];
  endfunction

  // largest lane difference, floored at zero, capped at full scale
  always_comb begin
    m = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (diffs[i] > m) m = diffs[i];
    end
    if (m > DIFF_W'(FULL_Q23)) m = DIFF_W'(FULL_Q23);
  end

  // factor operands, target rounding and smoothing sum
  always_comb begin
    tdelta = $signed({1'b0, trans_gain}) - $signed({1'b0, UNITY_Q20});
    sdelta = $signed({1'b0, sust_gain}) - $signed({1'b0, UNITY_Q20});
    xt     = $signed({1'b0, maxd});
    xs     = 25'sd8388608 - xt;
    t33    = 33'((49'(tsp) + 49'(32768)) >> 16);
    gdelta = $signed({1'b0, gain}) - $signed({1'b0, target});
    gsum   = $signed({2'b00, target, 24'b0}) + smprod + 58'sd8388608;
    g34    = gsum[57:24];
  end

  // smoothed gain state
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      gain <= UNITY_Q24;
    end else if (ctrl.smo_add) begin
      gain <= (|g34[33:32]) ? '1 : g34[31:0];
    end
  end

  // gain datapath
  always_ff @(posedge clk) begin
    if (ctrl.max)     maxd   <= m[23:0];
    if (ctrl.fac_mul) begin
      tprod <= tdelta * xt;
      sprod <= sdelta * xs;
    end
    if (ctrl.fac_add) begin
      tv <= shape(tprod);
      sv <= shape(sprod);
    end
    if (ctrl.tgt_mul) tsp    <= tv * sv;
    if (ctrl.tgt_rnd) target <= t33[32] ? '1 : t33[31:0];
    if (ctrl.smo_mul) smprod <= $signed({1'b0, smoothing}) * gdelta;
  end

endmodule

`default_nettype wire

/* rtl/transient_shaper.sv */
// transient_shaper: top level; configuration registers, frame sequencer,
// channel lanes, merge stage and output register; uses tshp_pkg, tshp_lane, tshp_merge
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  s_tdata: sample_ch0, sample_ch1
//   m_*       out        m_tvalid / m_tready  m_tdata: out_ch0, out_ch1, gain_value
//   cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// a frame steps through the sequencer states from one accepted transaction to the
// next accept; the envelope, gain and output multiplies run in turn on the per-channel
// lanes and the merge stage, one multiply per step; a bypassed frame goes to the last step.
// rst clears the envelopes, sets the gain to unity and loads register defaults.
// a result waits in the output register; the sequencer holds in its last step
// only while that register is still occupied.
`default_nettype none

module transient_shaper (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [47:0]                         s_tdata,   // sample_ch0, sample_ch1
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [79:0]                         m_tdata,   // out_ch0, out_ch1, gain_value
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tshp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tshp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tshp_pkg::*;

  logic [1:0]        active_channels;
  logic [COEF_W-1:0] fast_attack_coef;
  logic [COEF_W-1:0] fast_release_coef;
  logic [COEF_W-1:0] slow_attack_coef;
  logic [COEF_W-1:0] slow_release_coef;
  logic [COEF_W-1:0] smoothing_coef;
  logic [COEF_W-1:0] trans_gain_lin;
  logic [COEF_W-1:0] sust_gain_lin;

  state_t    state;
  state_t    state_next;
  seq_ctrl_t ctrl;

  logic                       cfg_write;
  logic                       in_accept;
  logic                       bypass;
  logic                       out_free;
  logic [CHANNELS-1:0]        act;
  diff_t                      diffs [CHANNELS];
  logic signed [SAMPLE_W-1:0] ys    [CHANNELS];
  logic [GAIN_W-1:0]          gain;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign bypass    = (active_channels == 2'd0) || (32'(active_channels) > CHANNELS);
  assign out_free  = !m_tvalid || m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels   <= 2'd2;
      fast_attack_coef  <= '0;
      fast_release_coef <= '0;
      slow_attack_coef  <= '0;
      slow_release_coef <= '0;
      smoothing_coef    <= '0;
      trans_gain_lin    <= UNITY_Q20;
      sust_gain_lin     <= UNITY_Q20;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACTIVE_CHANNELS: active_channels   <= cfg_data[1:0];
        REG_FAST_ATTACK:     fast_attack_coef  <= cfg_data;
        REG_FAST_RELEASE:    fast_release_coef <= cfg_data;
        REG_SLOW_ATTACK:     slow_attack_coef  <= cfg_data;
        REG_SLOW_RELEASE:    slow_release_coef <= cfg_data;
        REG_SMOOTHING:       smoothing_coef    <= cfg_data;
        REG_TRANSIENT_GAIN:  trans_gain_lin    <= cfg_data;
        REG_SUSTAIN_GAIN:    sust_gain_lin     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_accept) state_next = bypass ? ST_DONE : ST_ENV_MUL;
      ST_ENV_MUL: state_next = ST_ENV_ADD;
      ST_ENV_ADD: state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_MAX;
      ST_MAX:     state_next = ST_FAC_MUL;
      ST_FAC_MUL: state_next = ST_FAC_ADD;
      ST_FAC_ADD: state_next = ST_TGT_MUL;
      ST_TGT_MUL: state_next = ST_TGT_RND;
      ST_TGT_RND: state_next = ST_SMO_MUL;
      ST_SMO_MUL: state_next = ST_SMO_ADD;
      ST_SMO_ADD: state_next = ST_OUT_MUL;
      ST_OUT_MUL: state_next = ST_OUT_RND;
      ST_OUT_RND: state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // step strobes
  always_comb begin
    ctrl       = '0;
    ctrl.clear = cfg_write && (cfg_index == REG_ACTIVE_CHANNELS);
    case (state)
      ST_IDLE:    ctrl.load    = in_accept;
      ST_ENV_MUL: ctrl.env_mul = 1'b1;
      ST_ENV_ADD: ctrl.env_add = 1'b1;
      ST_DIFF:    ctrl.diff    = 1'b1;
      ST_MAX:     ctrl.max     = 1'b1;
      ST_FAC_MUL: ctrl.fac_mul = 1'b1;
      ST_FAC_ADD: ctrl.fac_add = 1'b1;
      ST_TGT_MUL: ctrl.tgt_mul = 1'b1;
      ST_TGT_RND: ctrl.tgt_rnd = 1'b1;
      ST_SMO_MUL: ctrl.smo_mul = 1'b1;
      ST_SMO_ADD: ctrl.smo_add = 1'b1;
      ST_OUT_MUL: ctrl.out_mul = 1'b1;
      ST_OUT_RND: ctrl.out_rnd = 1'b1;
      default: ;
    endcase
  end

  // channel lanes
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    assign act[i] = 32'(active_channels) > i;

    tshp_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .act      (act[i]),
      .sample   ($signed(s_tdata[i*SAMPLE_W +: SAMPLE_W])),
      .fast_att (fast_attack_coef),
      .fast_rel (fast_release_coef),
      .slow_att (slow_attack_coef),
      .slow_rel (slow_release_coef),
      .gain     (gain),
      .diff     (diffs[i]),
      .y        (ys[i])
    );
  end

  // transient amount and gain smoothing
  tshp_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .diffs      (diffs),
    .trans_gain (trans_gain_lin),
    .sust_gain  (sust_gain_lin),
    .smoothing  (smoothing_coef),
    .gain       (gain)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {gain, ys[1], ys[0]};
    end
  end

`ifndef SYNTH
  // no second frame enters while one is at work
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("frame accepted while another is in flight");

  // a channel count write restores unity gain
  a_clear_gain: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_ACTIVE_CHANNELS) |=> (gain == UNITY_Q24))
    else $error("gain not unity after channel count write");

  // a new result only leaves the final sequencer step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result raised outside the final step");
`endif

endmodule

`default_nettype wire

/* test/tb_transient_shaper.sv */
// tb_transient_shaper: self-checking testbench of the transient shaper, with a frame-level
// predictor in a scoreboard class, directed and random frames and register phases
// depends on tshp_pkg and transient_shaper
`default_nettype none

module tb_transient_shaper;
  import tshp_pkg::*;

  localparam int TOTAL_FRAMES = 700;
  localparam int QUIET_FRAMES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 5000;
  localparam int REPORT_MAX   = 10;

  // register indexes past the end of the map, which the block ignores
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = 4'd8;
  localparam logic [CFG_IDX_W-1:0] LAST_UNUSED_REG  = 4'd15;

  // channel counts outside 1..CHANNELS pass frames through untouched
  localparam logic [1:0] BYPASS_ZERO = 2'd0;
  localparam logic [1:0] BYPASS_HIGH = 2'd3;

  // one result transaction, laid out as on m_tdata
  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [SAMPLE_W-1:0] ch1;
    logic [SAMPLE_W-1:0] ch0;
  } shaped_frame_t;

  // predicts each shaped frame and checks the results against it
  class shaped_frame_board;
    logic [1:0]          channels;
    logic [COEF_W-1:0]   fast_att, fast_rel, slow_att, slow_rel, smooth;
    logic [COEF_W-1:0]   tr_gain, su_gain;
    logic [SAMPLE_W-1:0] fast_env [2];
    logic [SAMPLE_W-1:0] slow_env [2];
    logic [GAIN_W-1:0]   gain_state;
    shaped_frame_t       pending_frames [$];
    int                  mismatches;

    function new();
      channels   = 2'd2;
      fast_att   = '0;
      fast_rel   = '0;
      slow_att   = '0;
      slow_rel   = '0;
      smooth     = '0;
      tr_gain    = UNITY_Q20;
      su_gain    = UNITY_Q20;
      mismatches = 0;
      clear_dynamics();
    endfunction

    function void clear_dynamics();
      for (int ch = 0; ch < 2; ch++) begin
        fast_env[ch] = '0;
        slow_env[ch] = '0;
      end
      gain_state = UNITY_Q24;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ACTIVE_CHANNELS: begin
          channels = data[1:0];
          clear_dynamics();
        end
        REG_FAST_ATTACK:    fast_att = data;
        REG_FAST_RELEASE:   fast_rel = data;
        REG_SLOW_ATTACK:    slow_att = data;
        REG_SLOW_RELEASE:   slow_rel = data;
        REG_SMOOTHING:      smooth   = data;
        REG_TRANSIENT_GAIN: tr_gain  = data;
        REG_SUSTAIN_GAIN:   su_gain  = data;
        default: ;
      endcase
    endfunction

    // divide by 2^sh, rounding half away from zero
    function longint round_shift(longint v, int sh);
      longint half;
      half = longint'(1) << (sh - 1);
      if (v >= 0) return (v + half) >>> sh;
      return -((-v + half) >>> sh);
    endfunction

    // one-pole peak follower, attack pole when the magnitude rises
    function logic [SAMPLE_W-1:0] env_next(logic [SAMPLE_W-1:0] prev, logic [SAMPLE_W-1:0] mag,
                                           logic [COEF_W-1:0] att, logic [COEF_W-1:0] rel);
      logic [63:0] c;
      logic [63:0] acc;
      c = (mag > prev) ? att : rel;
      acc = prev * c + mag * (64'd16777216 - c) + 64'd8388608;
      return acc[47:24];
    endfunction

    // Q4.20 factor 1 + (g - 1) * x, x on the Q1.23 scale
    function longint shape_factor(logic [COEF_W-1:0] g, longint x);
      return 64'sd1048576 + round_shift((longint'(g) - 64'sd1048576) * x, 23);
    endfunction

    // accepted input transaction: advance the state and queue the result
    function void note_frame(logic [47:0] tdata);
      shaped_frame_t       want;
      logic signed [23:0]  s0, s1;
      longint              smp [2];
      longint              mag, d, maxdiff, tv, sv, y;
      longint unsigned     target, acc;
      int                  n;
      s0 = tdata[23:0];
      s1 = tdata[47:24];
      smp[0] = s0;
      smp[1] = s1;
      if (channels == 2'd0 || channels > CHANNELS) begin
        want.ch0  = tdata[23:0];
        want.ch1  = tdata[47:24];
        want.gain = gain_state;
        pending_frames.push_back(want);
        return;
      end
      n = channels;
      maxdiff = 0;
      for (int ch = 0; ch < n; ch++) begin
        mag = (smp[ch] < 0) ? -smp[ch] : smp[ch];
        fast_env[ch] = env_next(fast_env[ch], mag[23:0], fast_att, fast_rel);
        slow_env[ch] = env_next(slow_env[ch], mag[23:0], slow_att, slow_rel);
        d = longint'(fast_env[ch]) - longint'(slow_env[ch]);
        if (d > maxdiff) maxdiff = d;
      end
      if (maxdiff > FULL_Q23) maxdiff = FULL_Q23;

      // target gain from transient and sustain factors
      tv = shape_factor(tr_gain, maxdiff);
      sv = shape_factor(su_gain, FULL_Q23 - maxdiff);
      if (tv < 0) tv = 0;
      if (sv < 0) sv = 0;
      target = (tv * sv + 64'sd32768) >>> 16;
      if (target > 64'hFFFFFFFF) target = 64'hFFFFFFFF;

      // gain smoother
      acc = ((64'd16777216 - smooth) * target + smooth * gain_state + 64'd8388608) >> 24;
      if (acc > 64'hFFFFFFFF) acc = 64'hFFFFFFFF;
      gain_state = acc[31:0];

      // apply the gain, saturating to full scale
      for (int ch = 0; ch < 2; ch++) begin
        y = 0;
        if (ch < n) begin
          y = round_shift(smp[ch] * longint'(gain_state), 24);
          if (y > FULL_Q23 - 1) y = FULL_Q23 - 1;
          if (y < -FULL_Q23) y = -FULL_Q23;
        end
        if (ch == 0) want.ch0 = y[23:0];
        else want.ch1 = y[23:0];
      end
      want.gain = gain_state;
      pending_frames.push_back(want);
    endfunction

    // accepted result transaction against the oldest prediction
    function void check_frame(logic [79:0] tdata);
      shaped_frame_t got;
      shaped_frame_t want;
      got = tdata;
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: ch0 %h ch1 %h gain %h", got.ch0, got.ch1, got.gain);
        return;
      end
      want = pending_frames.pop_front();
      if (got.ch0 !== want.ch0 || got.ch1 !== want.ch1 || got.gain !== want.gain) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: expected ch0 %h ch1 %h gain %h, got ch0 %h ch1 %h gain %h",
                   want.ch0, want.ch1, want.gain, got.ch0, got.ch1, got.gain);
      end
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction

    // failures including predictions never matched by a result
    function int wrap_up();
      if (pending_frames.size() != 0)
        $display("missing results: %0d", pending_frames.size());
      return mismatches + pending_frames.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [47:0]           s_tdata;   // sample_ch0, sample_ch1
  logic                  m_tvalid;
  logic                  m_tready;
  logic [79:0]           m_tdata;   // out_ch0, out_ch1, gain_value
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  shaped_frame_board board;
  int                frames_sent;
  int                stall_cycles;
  bit                idle_on;
  bit                hold_request;
  bit                hold_done;
  int                ready_left;

  transient_shaper uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_frame(m_tdata);
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random ready bursts and one long hold-off
  initial begin
    m_tready   = 1'b0;
    ready_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done  = 1'b1;
        ready_left = 0;
      end else if (ready_left > 0) begin
        ready_left--;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        m_tready   <= 1'b0;
        ready_left = $urandom_range(0, 6);
      end else begin
        m_tready   <= 1'b1;
        ready_left = $urandom_range(0, 14);
      end
    end
  end

  // one register write transaction
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // channel count with random upper bits in the data word
  task automatic write_channels(logic [1:0] count);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data[1:0] = count;
    write_reg(REG_ACTIVE_CHANNELS, data);
  endtask

  // one input frame transaction, with an optional gap before it
  task automatic send_frame(logic [23:0] smp0, logic [23:0] smp1);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tdata  <= {smp1, smp0};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_frame({smp1, smp0});
    frames_sent++;
    if (TOTAL_FRAMES - frames_sent <= QUIET_FRAMES) idle_on = 1'b0;
    @(negedge clk);
  endtask

  // wait until every predicted result has come back, then let the block settle
  task automatic drain_results();
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // envelope pole: extremes, full range, or close to one
  function automatic logic [COEF_W-1:0] gen_pole(bit slow);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return COEF_W'($urandom);
      default: begin
        if (slow) return COEF_W'(24'hFFFFFF - $urandom_range(0, 24'h3FFFF));
        return COEF_W'(24'hFFFFFF - $urandom_range(0, 24'h3FFFFF));
      end
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] gen_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return UNITY_Q20;
      3: return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(0, 24'h3FFFFF));
    endcase
  endfunction

  // mostly quiet audio with extremes and full-range values mixed in
  function automatic logic [23:0] gen_sample();
    logic signed [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(0, 15))
      0: begin
        case ($urandom_range(0, 4))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'h000000;
          3: return 24'hFFFFFF;
          default: return 24'h000001;
        endcase
      end
      1, 2, 3: return v;
      default: return v >>> $urandom_range(4, 12);
    endcase
  endfunction

  // new setting of every register
  task automatic randomize_config();
    logic [1:0] count;
    case ($urandom_range(0, 9))
      0: count = BYPASS_ZERO;
      1: count = BYPASS_HIGH;
      2, 3, 4: count = 2'd1;
      default: count = 2'd2;
    endcase
    write_channels(count);
    write_reg(REG_FAST_ATTACK, gen_pole(1'b0));
    write_reg(REG_FAST_RELEASE, gen_pole(1'b0));
    write_reg(REG_SLOW_ATTACK, gen_pole(1'b1));
    write_reg(REG_SLOW_RELEASE, gen_pole(1'b1));
    write_reg(REG_SMOOTHING, gen_pole(1'b0));
    write_reg(REG_TRANSIENT_GAIN, gen_gain());
    write_reg(REG_SUSTAIN_GAIN, gen_gain());
    if ($urandom_range(0, 4) == 0)
      write_reg(CFG_IDX_W'($urandom_range(LAST_UNUSED_REG, FIRST_UNUSED_REG)),
                CFG_DATA_W'($urandom));
  endtask

  // stimulus
  initial begin
    int         len;
    int         phase;
    logic [23:0] spike;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    frames_sent  = 0;
    stall_cycles = 0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    board        = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: sample extremes on both channels
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h000000, 24'h000000);
    send_frame(24'hFFFFFF, 24'h000001);
    send_frame(24'h400000, 24'hC00000);
    s_tvalid <= 1'b0;
    drain_results();

    // instant fast attack against a frozen slow envelope, huge transient gain
    write_reg(REG_FAST_ATTACK, 24'h000000);
    write_reg(REG_FAST_RELEASE, 24'hFFFFFF);
    write_reg(REG_SLOW_ATTACK, 24'hFFFFFF);
    write_reg(REG_SLOW_RELEASE, 24'hFFFFFF);
    write_reg(REG_SMOOTHING, 24'h000000);
    write_reg(REG_TRANSIENT_GAIN, 24'hFFFFFF);
    write_reg(REG_SUSTAIN_GAIN, 24'h000000);
    write_channels(2'd2);
    send_frame(24'h7FFFFF, 24'h000000);
    send_frame(24'h800000, 24'h800000);
    send_frame(24'h000000, 24'h000000);
    send_frame(24'h7FFFFF, 24'h7FFFFF);
    s_tvalid <= 1'b0;
    drain_results();

    // one channel, sustain emphasis with the slowest smoother
    write_channels(2'd1);
    write_reg(REG_TRANSIENT_GAIN, 24'h000000);
    write_reg(REG_SUSTAIN_GAIN, 24'hFFFFFF);
    write_reg(REG_SMOOTHING, 24'hFFFFFF);
    send_frame(24'h100000, 24'h7FFFFF);
    send_frame(24'h800000, 24'h800000);
    send_frame(24'h7FFFFF, 24'h123456);
    s_tvalid <= 1'b0;
    drain_results();

    // unused register indexes, then both bypass counts
    write_reg(FIRST_UNUSED_REG, 24'hFFFFFF);
    write_reg(LAST_UNUSED_REG, 24'h000003);
    write_channels(BYPASS_ZERO);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'hABCDEF, 24'h543210);
    s_tvalid <= 1'b0;
    drain_results();
    write_channels(BYPASS_HIGH);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h000001, 24'hFFFFFF);
    s_tvalid <= 1'b0;

    // random phases; the third one holds the receiver off
    phase = 0;
    while (frames_sent < TOTAL_FRAMES) begin
      drain_results();
      randomize_config();
      if (phase == 2) begin
        hold_request = 1'b1;
        len = 80;
      end else begin
        len = $urandom_range(30, 80);
      end
      for (int i = 0; i < len && frames_sent < TOTAL_FRAMES; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          spike = $urandom_range(0, 1) ? 24'(24'h7FFFFF - $urandom_range(0, 24'h0FFFFF))
                                       : 24'(24'h800000 + $urandom_range(0, 24'h0FFFFF));
          send_frame(spike, spike);
        end else begin
          send_frame(gen_sample(), gen_sample());
        end
      end
      s_tvalid <= 1'b0;
      phase++;
    end

    // wrap-up
    idle_on = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.wrap_up() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
